[hdl/mdls_pkg.sv]
// mdls_pkg: shared constants, register codes and controller/datapath structs
// for the multicolor dash line segmenter
// no dependencies
package mdls_pkg;

  localparam int MdlsMaxSegments  = 64;
  localparam int MdlsCoordWidth   = 16;
  localparam int MdlsDashLenWidth = 10;

  localparam int ColorWidth     = 4;
  localparam int ThickWidth     = 8;
  localparam int SegIndexWidth  = 6;
  localparam int PhaseWidth     = 13;
  localparam int PhaseMin       = -4096;
  localparam int PhaseMax       = 4095;
  localparam int FracBits       = 12;
  localparam int QuotWidth      = 17;
  localparam int RegAddrWidth   = 5;
  localparam int ApbDataWidth   = 32;

  typedef enum logic [2:0] {
    REG_DASH0_LEN   = 3'd0,
    REG_DASH1_LEN   = 3'd1,
    REG_DASH2_LEN   = 3'd2,
    REG_DASH0_COLOR = 3'd3,
    REG_DASH1_COLOR = 3'd4,
    REG_DASH2_COLOR = 3'd5,
    REG_THREE_MODE  = 3'd6,
    REG_THICKNESS   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic load_in;
    logic emit_plain;
    logic sq_x;
    logic sq_y;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic walk_init;
    logic walk_adv;
    logic seg_latch;
    logic mul_issue;
    logic pt_conv;
    logic emit_seg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic plain;
    logic len_zero;
    logic cnt_last;
    logic div_sel_y;
    logic past_end;
    logic visible;
    logic pt_last;
    logic stop;
    logic out_free;
  } ctrl_sts_t;

endpackage

[hdl/mdls_if.sv]
// mdls_line_if and mdls_seg_if: valid/ready channels for lines and segments
// depends on mdls_pkg
interface mdls_line_if import mdls_pkg::*; #(
  parameter int COORD_WIDTH = MdlsCoordWidth
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mdls_seg_if import mdls_pkg::*; #(
  parameter int COORD_WIDTH = MdlsCoordWidth
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;
  logic [ColorWidth-1:0]         seg_color;
  logic [ThickWidth-1:0]         seg_thickness;
  logic [SegIndexWidth-1:0]      seg_index;
  logic                          last_segment;
  logic                          truncated;

  modport source(output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, seg_color,
                 seg_thickness, seg_index, last_segment, truncated, input ready);
  modport sink(input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, seg_color,
               seg_thickness, seg_index, last_segment, truncated, output ready);
endinterface

[hdl/mdls_cfg.sv]
// mdls_cfg: apb register file for dash lengths, colors, mode and thickness
// depends on mdls_pkg
module mdls_cfg import mdls_pkg::*; #(
  parameter int DASH_LEN_WIDTH = MdlsDashLenWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [RegAddrWidth-1:0]             paddr,
  input  logic [ApbDataWidth-1:0]             pwdata,
  output logic [ApbDataWidth-1:0]             prdata,
  output logic                                pready,
  output logic [2:0][DASH_LEN_WIDTH-1:0]      dash_len_o,
  output logic [2:0][ColorWidth-1:0]          dash_color_o,
  output logic                                three_mode_o,
  output logic [ThickWidth-1:0]               thickness_o
);

  logic [2:0][DASH_LEN_WIDTH-1:0] len_q;
  logic [2:0][ColorWidth-1:0]     color_q;
  logic                           three_q;
  logic [ThickWidth-1:0]          thick_q;
  logic                           wr_en;
  reg_idx_e                       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[RegAddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0]   <= DASH_LEN_WIDTH'(8);
      len_q[1]   <= DASH_LEN_WIDTH'(8);
      len_q[2]   <= '0;
      color_q[0] <= ColorWidth'(1);
      color_q[1] <= '0;
      color_q[2] <= '0;
      three_q    <= 1'b0;
      thick_q    <= ThickWidth'(4);
    end else if (wr_en) begin
      unique case (idx)
        REG_DASH0_LEN:   len_q[0]   <= pwdata[DASH_LEN_WIDTH-1:0];
        REG_DASH1_LEN:   len_q[1]   <= pwdata[DASH_LEN_WIDTH-1:0];
        REG_DASH2_LEN:   len_q[2]   <= pwdata[DASH_LEN_WIDTH-1:0];
        REG_DASH0_COLOR: color_q[0] <= pwdata[ColorWidth-1:0];
        REG_DASH1_COLOR: color_q[1] <= pwdata[ColorWidth-1:0];
        REG_DASH2_COLOR: color_q[2] <= pwdata[ColorWidth-1:0];
        REG_THREE_MODE:  three_q    <= pwdata[0];
        REG_THICKNESS:   thick_q    <= pwdata[ThickWidth-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DASH0_LEN:   prdata = ApbDataWidth'(len_q[0]);
      REG_DASH1_LEN:   prdata = ApbDataWidth'(len_q[1]);
      REG_DASH2_LEN:   prdata = ApbDataWidth'(len_q[2]);
      REG_DASH0_COLOR: prdata = ApbDataWidth'(color_q[0]);
      REG_DASH1_COLOR: prdata = ApbDataWidth'(color_q[1]);
      REG_DASH2_COLOR: prdata = ApbDataWidth'(color_q[2]);
      REG_THREE_MODE:  prdata = ApbDataWidth'(three_q);
      REG_THICKNESS:   prdata = ApbDataWidth'(thick_q);
      default:         prdata = '0;
    endcase
  end

  assign dash_len_o   = len_q;
  assign dash_color_o = color_q;
  assign three_mode_o = three_q;
  assign thickness_o  = thick_q;

endmodule

[hdl/mdls_ctrl.sv]
// mdls_ctrl: sequencer for one line: squares, square root, two divides,
// then the dash walk with one output transaction per emitted dash
// depends on mdls_pkg
module mdls_ctrl import mdls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_PLAIN = 12'b0000_0000_0010,
    ST_SQX   = 12'b0000_0000_0100,
    ST_SQY   = 12'b0000_0000_1000,
    ST_SINIT = 12'b0000_0001_0000,
    ST_SQRT  = 12'b0000_0010_0000,
    ST_DINIT = 12'b0000_0100_0000,
    ST_DIV   = 12'b0000_1000_0000,
    ST_WINIT = 12'b0001_0000_0000,
    ST_STEP  = 12'b0010_0000_0000,
    ST_MUL   = 12'b0100_0000_0000,
    ST_PT    = 12'b1000_0000_0000
  } state_e;

  // emit shares the point state group: a separate flag marks the output wait
  state_e state_q, state_d;
  logic   emit_q, emit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    emit_d     = emit_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = sts_i.plain ? ST_PLAIN : ST_SQX;
        end
      end
      ST_PLAIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_plain = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SQX: begin
        if (sts_i.len_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.sq_x = 1'b1;
          state_d = ST_SQY;
        end
      end
      ST_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d = ST_SINIT;
      end
      ST_SINIT: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.cnt_last) state_d = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_last) state_d = sts_i.div_sel_y ? ST_WINIT : ST_DINIT;
      end
      ST_WINIT: begin
        cmd_o.walk_init = 1'b1;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (sts_i.past_end) begin
          state_d = ST_IDLE;
        end else if (sts_i.visible) begin
          cmd_o.seg_latch = 1'b1;
          state_d = ST_MUL;
        end else begin
          cmd_o.walk_adv = 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul_issue = 1'b1;
        state_d = ST_PT;
      end
      ST_PT: begin
        if (!emit_q) begin
          cmd_o.pt_conv = 1'b1;
          if (sts_i.pt_last) emit_d = 1'b1;
          else state_d = ST_MUL;
        end else if (sts_i.out_free) begin
          cmd_o.emit_seg = 1'b1;
          emit_d  = 1'b0;
          state_d = sts_i.stop ? ST_IDLE : ST_STEP;
        end
      end
      default: begin
        state_d = ST_IDLE;
        emit_d  = 1'b0;
      end
    endcase
  end

endmodule

[hdl/mdls_dpath.sv]
// mdls_dpath: endpoint registers, squares, bit-serial square root and divider,
// dash walk, point multiplier and the output register
// depends on mdls_pkg
module mdls_dpath import mdls_pkg::*; #(
  parameter int MAX_SEGMENTS   = MdlsMaxSegments,
  parameter int COORD_WIDTH    = MdlsCoordWidth,
  parameter int DASH_LEN_WIDTH = MdlsDashLenWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctrl_cmd_t                      cmd_i,
  output ctrl_sts_t                      sts_o,
  input  logic signed [COORD_WIDTH-1:0]  start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  end_y_i,
  input  logic [2:0][DASH_LEN_WIDTH-1:0] dash_len_i,
  input  logic [2:0][ColorWidth-1:0]     dash_color_i,
  input  logic                           three_mode_i,
  input  logic [ThickWidth-1:0]          thickness_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [COORD_WIDTH-1:0]  seg_start_x_o,
  output logic signed [COORD_WIDTH-1:0]  seg_start_y_o,
  output logic signed [COORD_WIDTH-1:0]  seg_end_x_o,
  output logic signed [COORD_WIDTH-1:0]  seg_end_y_o,
  output logic [ColorWidth-1:0]          seg_color_o,
  output logic [ThickWidth-1:0]          seg_thickness_o,
  output logic [SegIndexWidth-1:0]       seg_index_o,
  output logic                           last_segment_o,
  output logic                           truncated_o
);

  localparam int W    = COORD_WIDTH;
  localparam int DLW  = DASH_LEN_WIDTH;
  localparam int SW   = 2 * W + 1;
  localparam int RTW  = W + 9;
  localparam int RW   = 2 * RTW;
  localparam int LFW  = RTW - FracBits;
  localparam int QW   = QuotWidth;
  localparam int NW   = W + 25;
  localparam int PW   = LFW + QW;
  localparam int OW   = PW - FracBits + 1;
  localparam int EW   = ((W > OW) ? W : OW) + 2;
  localparam int ZB0  = (LFW > DLW + 2) ? LFW : DLW + 2;
  localparam int ZW   = ((ZB0 > PhaseWidth) ? ZB0 : PhaseWidth) + 2;
  localparam int PHW  = ZW + 2;
  localparam int CNTN = (RTW > QW) ? RTW : QW;
  localparam int CW   = $clog2(CNTN + 1);
  localparam int SCW  = $clog2(MAX_SEGMENTS);

  // line endpoints and direction
  logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [W-1:0]        ax_q, ay_q;
  logic                negx_q, negy_q;
  logic signed [W:0]   dx, dy;

  // squares, root, divider
  logic [2*W-1:0] sx_q, sy_q;
  logic [RW-1:0]  rad_q;
  logic [RTW-1:0] root_q;
  logic [RTW:0]   srem_q;
  logic [CW-1:0]  cnt_q;
  logic [RTW-1:0] drem_q;
  logic [QW-1:0]  dnum_q, dq_q, ux_q, uy_q;
  logic           div_sel_q;
  logic [LFW-1:0] lf_q;
  logic [LFW:0]   lc_q;

  // dash walk
  logic signed [ZW-1:0] z_q, zb_q;
  logic [1:0]           k_q, k_next;
  logic [SCW-1:0]       count_q;
  logic [LFW-1:0]       za_q;
  logic                 at_end_q;
  logic [1:0]           pt_sel_q;
  logic [PW-1:0]        prod_q;
  logic signed [W-1:0]  pt_q [4];
  logic signed [PhaseWidth-1:0] phase_q;

  // output register
  logic                   ov_q;
  logic signed [W-1:0]    o_sx_q, o_sy_q, o_ex_q, o_ey_q;
  logic [ColorWidth-1:0]  o_col_q;
  logic [ThickWidth-1:0]  o_thk_q;
  logic [SegIndexWidth-1:0] o_idx_q;
  logic                   o_last_q, o_trunc_q;

  assign dx = {end_x_i[W-1], end_x_i} - {start_x_i[W-1], start_x_i};
  assign dy = {end_y_i[W-1], end_y_i} - {start_y_i[W-1], start_y_i};

  // pattern setup
  logic [DLW-1:0]   len2_eff, len_k;
  logic [DLW+1:0]   span;
  logic [DLW:0]     later;
  logic [ColorWidth-1:0] col_k;

  assign len2_eff = three_mode_i ? dash_len_i[2] : '0;
  assign span = (DLW+2)'(dash_len_i[0]) + (DLW+2)'(dash_len_i[1]) + (DLW+2)'(len2_eff);

  always_comb begin
    unique case (k_q)
      2'd0: begin
        len_k = dash_len_i[0];
        col_k = dash_color_i[0];
        later = (DLW+1)'(dash_len_i[1]) + (DLW+1)'(len2_eff);
      end
      2'd1: begin
        len_k = dash_len_i[1];
        col_k = dash_color_i[1];
        later = (DLW+1)'(len2_eff);
      end
      2'd2: begin
        len_k = len2_eff;
        col_k = dash_color_i[2];
        later = '0;
      end
      default: begin
        len_k = '0;
        col_k = '0;
        later = '0;
      end
    endcase
  end

  assign k_next = (k_q == (three_mode_i ? 2'd2 : 2'd1)) ? 2'd0 : k_q + 2'd1;

  // square root step
  logic [RTW+2:0] rem_n, trial;
  logic           sq_ge;
  assign rem_n = {srem_q, rad_q[RW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign sq_ge = rem_n >= trial;

  // divider step
  logic [W-1:0]   div_a;
  logic [NW-1:0]  num;
  logic [RTW:0]   dt, droot;
  logic           dv_ge;
  logic [QW-1:0]  dq_n;
  assign div_a = div_sel_q ? ay_q : ax_q;
  assign num   = (NW'(div_a) << 24) + NW'(root_q >> 1);
  assign dt    = {drem_q, dnum_q[QW-1]};
  assign droot = {1'b0, root_q};
  assign dv_ge = dt >= droot;
  assign dq_n  = {dq_q[QW-2:0], dv_ge};

  // length floor and ceiling
  logic           r_inexact;
  assign r_inexact = (srem_q != '0) || (root_q[FracBits-1:0] != '0);

  // walk
  logic signed [ZW-1:0] span_z, phase_z, lf_z, zb_c, z_init;
  assign span_z  = ZW'(span);
  assign phase_z = ZW'(phase_q);
  assign lf_z    = ZW'(lf_q);
  assign zb_c    = z_q + ZW'(len_k);
  assign z_init  = -span_z - phase_z;

  // new phase at the line end
  logic signed [PHW-1:0] lc_p, zb_p, later_p, ph;
  logic signed [PhaseWidth-1:0] ph_sat;
  assign lc_p    = PHW'(lc_q);
  assign zb_p    = PHW'(zb_q);
  assign later_p = PHW'(later);
  assign ph      = lc_p - zb_p - later_p;

  always_comb begin
    if (ph < PHW'(PhaseMin)) ph_sat = PhaseWidth'(PhaseMin);
    else if (ph > PHW'(PhaseMax)) ph_sat = PhaseWidth'(PhaseMax);
    else ph_sat = ph[PhaseWidth-1:0];
  end

  // point conversion: round, apply sign, clamp between the endpoints
  logic [LFW-1:0]         zop;
  logic [QW-1:0]          uop;
  logic [PW:0]            rnd;
  logic signed [EW-1:0]   p1_e, p2_e, off_e, p_e, lo_e, hi_e, pc_e;
  logic                   neg_sel;

  assign zop   = pt_sel_q[1] ? zb_q[LFW-1:0] : za_q;
  assign uop   = pt_sel_q[0] ? uy_q : ux_q;
  assign rnd   = (PW+1)'(prod_q) + (PW+1)'(2048);
  assign off_e = EW'(rnd[PW:FracBits]);
  assign p1_e  = pt_sel_q[0] ? EW'(y1_q) : EW'(x1_q);
  assign p2_e  = pt_sel_q[0] ? EW'(y2_q) : EW'(x2_q);
  assign neg_sel = pt_sel_q[0] ? negy_q : negx_q;
  assign p_e   = neg_sel ? p1_e - off_e : p1_e + off_e;
  assign lo_e  = (p1_e < p2_e) ? p1_e : p2_e;
  assign hi_e  = (p1_e < p2_e) ? p2_e : p1_e;

  always_comb begin
    if (p_e < lo_e) pc_e = lo_e;
    else if (p_e > hi_e) pc_e = hi_e;
    else pc_e = p_e;
  end

  logic full;
  assign full = (count_q == SCW'(MAX_SEGMENTS - 1));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      div_sel_q <= 1'b0;
      k_q       <= '0;
      count_q   <= '0;
      pt_sel_q  <= '0;
      phase_q   <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (cmd_i.load_in) div_sel_q <= 1'b0;
      if (cmd_i.sqrt_init) cnt_q <= CW'(RTW);
      if (cmd_i.div_init) cnt_q <= CW'(QW);
      if (cmd_i.sqrt_step || cmd_i.div_step) cnt_q <= cnt_q - CW'(1);
      if (cmd_i.div_step && sts_o.cnt_last) div_sel_q <= !div_sel_q;
      if (cmd_i.walk_init) begin
        k_q     <= '0;
        count_q <= '0;
      end
      if (cmd_i.walk_adv) k_q <= k_next;
      if (cmd_i.seg_latch) pt_sel_q <= '0;
      if (cmd_i.pt_conv) pt_sel_q <= pt_sel_q + 2'd1;
      if (cmd_i.emit_seg) begin
        if (at_end_q) begin
          phase_q <= ph_sat;
        end else if (!full) begin
          count_q <= count_q + SCW'(1);
          k_q     <= k_next;
        end
      end
      if (cmd_i.emit_plain || cmd_i.emit_seg) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x1_q   <= start_x_i;
      y1_q   <= start_y_i;
      x2_q   <= end_x_i;
      y2_q   <= end_y_i;
      negx_q <= dx[W];
      negy_q <= dy[W];
      ax_q   <= dx[W] ? W'(-dx) : W'(dx);
      ay_q   <= dy[W] ? W'(-dy) : W'(dy);
    end
    if (cmd_i.sq_x) sx_q <= ax_q * ax_q;
    if (cmd_i.sq_y) sy_q <= ay_q * ay_q;
    if (cmd_i.sqrt_init) begin
      rad_q  <= RW'({SW'(sx_q) + SW'(sy_q), 16'h0000});
      root_q <= '0;
      srem_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q  <= rad_q << 2;
      root_q <= {root_q[RTW-2:0], sq_ge};
      srem_q <= sq_ge ? (RTW+1)'(rem_n - trial) : rem_n[RTW:0];
    end
    if (cmd_i.div_init) begin
      drem_q <= RTW'(num >> QW);
      dnum_q <= num[QW-1:0];
      dq_q   <= '0;
      lf_q   <= root_q[RTW-1:FracBits];
      lc_q   <= (LFW+1)'(root_q[RTW-1:FracBits]) + (LFW+1)'(r_inexact);
    end
    if (cmd_i.div_step) begin
      drem_q <= dv_ge ? RTW'(dt - droot) : RTW'(dt);
      dnum_q <= dnum_q << 1;
      dq_q   <= dq_n;
      if (sts_o.cnt_last) begin
        if (div_sel_q) uy_q <= dq_n;
        else ux_q <= dq_n;
      end
    end
    if (cmd_i.walk_init) z_q <= z_init;
    if (cmd_i.walk_adv) z_q <= zb_c;
    if (cmd_i.seg_latch) begin
      za_q     <= z_q[ZW-1] ? '0 : z_q[LFW-1:0];
      zb_q     <= zb_c;
      at_end_q <= zb_c > lf_z;
    end
    if (cmd_i.mul_issue) prod_q <= PW'(zop) * PW'(uop);
    if (cmd_i.pt_conv) pt_q[pt_sel_q] <= pc_e[W-1:0];
    if (cmd_i.emit_seg && !at_end_q && !full) z_q <= zb_q;

    if (cmd_i.emit_plain) begin
      o_sx_q    <= x1_q;
      o_sy_q    <= y1_q;
      o_ex_q    <= x2_q;
      o_ey_q    <= y2_q;
      o_col_q   <= dash_color_i[0];
      o_thk_q   <= thickness_i;
      o_idx_q   <= '0;
      o_last_q  <= 1'b1;
      o_trunc_q <= 1'b0;
    end
    if (cmd_i.emit_seg) begin
      o_sx_q    <= pt_q[0];
      o_sy_q    <= pt_q[1];
      o_ex_q    <= at_end_q ? x2_q : pt_q[2];
      o_ey_q    <= at_end_q ? y2_q : pt_q[3];
      o_col_q   <= col_k;
      o_thk_q   <= thickness_i;
      o_idx_q   <= SegIndexWidth'(count_q);
      o_last_q  <= at_end_q || full;
      o_trunc_q <= !at_end_q && full;
    end
  end

  always_comb begin
    sts_o.plain     = (span == '0) ||
                      (three_mode_i ? (dash_color_i[1] == '0 && dash_color_i[2] == '0)
                                    : (dash_color_i[1] == '0));
    sts_o.len_zero  = (ax_q == '0) && (ay_q == '0);
    sts_o.cnt_last  = (cnt_q == CW'(1));
    sts_o.div_sel_y = div_sel_q;
    sts_o.past_end  = z_q > lf_z;
    sts_o.visible   = !zb_c[ZW-1];
    sts_o.pt_last   = at_end_q ? (pt_sel_q == 2'd1) : (pt_sel_q == 2'd3);
    sts_o.stop      = at_end_q || full;
    sts_o.out_free  = !ov_q || out_ready_i;
  end

  assign out_valid_o     = ov_q;
  assign seg_start_x_o   = o_sx_q;
  assign seg_start_y_o   = o_sy_q;
  assign seg_end_x_o     = o_ex_q;
  assign seg_end_y_o     = o_ey_q;
  assign seg_color_o     = o_col_q;
  assign seg_thickness_o = o_thk_q;
  assign seg_index_o     = o_idx_q;
  assign last_segment_o  = o_last_q;
  assign truncated_o     = o_trunc_q;

endmodule

[hdl/multicolor_dash_line_segmenter.sv]
// multicolor_dash_line_segmenter: top level, joins register file, controller
// and datapath; depends on mdls_pkg, mdls_if, mdls_cfg, mdls_ctrl, mdls_dpath
//
// Splits each line into colored dashes of a repeating two- or three-dash
// pattern whose phase carries over from line to line. One line is in work at
// a time; the next line is taken once the last segment of the current one sits
// in the output register. A plain line (pattern span zero or later colors zero)
// is passed on whole as a single segment. A patterned line first runs the
// squares, the one-bit-per-cycle square root (COORD_WIDTH+9 steps) and two
// 17-step divides for the unit vector; then each emitted dash goes through the
// shared point multiplier (two points at the line end, else four), while
// dashes before the line start are skipped. A zero-length patterned line ends
// with no output. Output back-pressure stalls the emits.
module multicolor_dash_line_segmenter import mdls_pkg::*; #(
  parameter int MAX_SEGMENTS   = MdlsMaxSegments,
  parameter int COORD_WIDTH    = MdlsCoordWidth,
  parameter int DASH_LEN_WIDTH = MdlsDashLenWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [RegAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  mdls_line_if.sink               line_i,
  mdls_seg_if.source              seg_o
);

  logic [2:0][DASH_LEN_WIDTH-1:0] dash_len;
  logic [2:0][ColorWidth-1:0]     dash_color;
  logic                           three_mode;
  logic [ThickWidth-1:0]          thickness;
  ctrl_cmd_t                      cmd;
  ctrl_sts_t                      sts;

  mdls_cfg #(
    .DASH_LEN_WIDTH(DASH_LEN_WIDTH)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .dash_len_o   (dash_len),
    .dash_color_o (dash_color),
    .three_mode_o (three_mode),
    .thickness_o  (thickness)
  );

  mdls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (line_i.valid),
    .in_ready_o (line_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mdls_dpath #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .COORD_WIDTH   (COORD_WIDTH),
    .DASH_LEN_WIDTH(DASH_LEN_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_x_i       (line_i.start_x),
    .start_y_i       (line_i.start_y),
    .end_x_i         (line_i.end_x),
    .end_y_i         (line_i.end_y),
    .dash_len_i      (dash_len),
    .dash_color_i    (dash_color),
    .three_mode_i    (three_mode),
    .thickness_i     (thickness),
    .out_ready_i     (seg_o.ready),
    .out_valid_o     (seg_o.valid),
    .seg_start_x_o   (seg_o.seg_start_x),
    .seg_start_y_o   (seg_o.seg_start_y),
    .seg_end_x_o     (seg_o.seg_end_x),
    .seg_end_y_o     (seg_o.seg_end_y),
    .seg_color_o     (seg_o.seg_color),
    .seg_thickness_o (seg_o.seg_thickness),
    .seg_index_o     (seg_o.seg_index),
    .last_segment_o  (seg_o.last_segment),
    .truncated_o     (seg_o.truncated)
  );

`ifndef SYNTHESIS
  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid && seg_o.truncated |-> seg_o.last_segment)
    else $error("truncated segment without last_segment");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid |-> (seg_o.seg_index <= SegIndexWidth'(MAX_SEGMENTS - 1)))
    else $error("segment index beyond limit");

  a_one_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_i.valid && line_i.ready |=> !line_i.ready)
    else $error("second line taken while one is in work");
`endif

endmodule
